// ----- design/sspp_pkg.sv -----
package sspp_pkg;

  localparam logic [7:0] HDR_BYTE  = 8'hFF;
  localparam logic [8:0] LEN_EXTRA = 9'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_EXPECTED_ID    = 2'd0;
  localparam logic [1:0] REG_PAYLOAD_LENGTH = 2'd1;
  localparam logic [1:0] REG_MATCH_ANY_ID   = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_ERR  = 3'd2,
    PH_DATA = 3'd3,
    PH_SUM  = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_GOOD      = 2'd1,
    KIND_BAD       = 2'd2,
    KIND_NO_PACKET = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] expected_id;
    logic [7:0] payload_length;
    logic       match_any_id;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       burst_end;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic [7:0] servo_id;
    logic [7:0] status_error;
    logic       last;
  } result_t;

endpackage

// ----- design/sspp_in_stage.sv -----
module sspp_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sspp_pkg::item_t in_item,
  input  logic           advance,
  output logic           held_valid,
  output sspp_pkg::item_t held_item
);
  import sspp_pkg::*;

  // Refill in the same cycle the held item moves on
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

// ----- design/sspp_parser.sv -----
module sspp_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step_en,
  input  sspp_pkg::item_t  item,
  input  sspp_pkg::cfg_t   cfg,
  output logic             res_valid,
  output sspp_pkg::result_t res
);
  import sspp_pkg::*;

  logic [7:0] window_older, window_older_next;
  logic [7:0] window_newer, window_newer_next;
  phase_t     phase, phase_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] held_id, held_id_next;
  logic [7:0] held_error, held_error_next;
  logic       finished;
  logic [7:0] count_inc;
  logic [7:0] b;

  assign b         = item.rx_byte;
  assign count_inc = byte_count + 8'd1;

  always_comb begin
    window_older_next = window_older;
    window_newer_next = window_newer;
    phase_next        = phase;
    byte_count_next   = byte_count;
    running_sum_next  = running_sum;
    held_id_next      = held_id;
    held_error_next   = held_error;
    finished          = 1'b0;
    res_valid         = 1'b0;
    res               = '0;

    case (phase)
      PH_HUNT: begin
        if (window_older == HDR_BYTE && window_newer == HDR_BYTE && b != HDR_BYTE) begin
          window_older_next = '0;
          window_newer_next = '0;
          if (cfg.match_any_id || b == cfg.expected_id) begin
            held_id_next = b;
            phase_next   = PH_LEN;
          end
        end else begin
          window_older_next = window_newer;
          window_newer_next = b;
        end
      end
      PH_LEN: begin
        // compared without wrap: lengths 254 and 255 never match
        if ({1'b0, b} != {1'b0, cfg.payload_length} + LEN_EXTRA) begin
          window_older_next = '0;
          window_newer_next = '0;
          phase_next        = PH_HUNT;
          byte_count_next   = '0;
          running_sum_next  = '0;
          held_id_next      = '0;
          held_error_next   = '0;
        end else begin
          running_sum_next = held_id + b;
          phase_next       = PH_ERR;
        end
      end
      PH_ERR: begin
        held_error_next  = b;
        running_sum_next = running_sum + b;
        byte_count_next  = '0;
        phase_next       = (cfg.payload_length == 8'd0) ? PH_SUM : PH_DATA;
      end
      PH_DATA: begin
        res_valid          = 1'b1;
        res.kind           = KIND_DATA;
        res.data_byte      = b;
        res.data_index     = byte_count;
        res.servo_id       = held_id;
        res.status_error   = held_error;
        res.last           = 1'b0;
        running_sum_next   = running_sum + b;
        byte_count_next    = count_inc;
        if (count_inc >= cfg.payload_length) begin
          phase_next = PH_SUM;
        end
      end
      PH_SUM: begin
        res_valid        = 1'b1;
        res.kind         = (~running_sum == b) ? KIND_GOOD : KIND_BAD;
        res.servo_id     = held_id;
        res.status_error = held_error;
        res.last         = 1'b1;
        finished         = 1'b1;
        phase_next       = PH_DONE;
      end
      default: begin
        finished   = 1'b1;
        phase_next = PH_DONE;
      end
    endcase

    // Burst end returns the parser to hunting; unless the packet finished, no packet is reported
    if (item.burst_end) begin
      if (!finished) begin
        res_valid = 1'b1;
        res       = '0;
        res.kind  = KIND_NO_PACKET;
        res.last  = 1'b1;
      end
      window_older_next = '0;
      window_newer_next = '0;
      phase_next        = PH_HUNT;
      byte_count_next   = '0;
      running_sum_next  = '0;
      held_id_next      = '0;
      held_error_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_older <= '0;
      window_newer <= '0;
      phase        <= PH_HUNT;
      byte_count   <= '0;
      running_sum  <= '0;
      held_id      <= '0;
      held_error   <= '0;
    end else if (step_en) begin
      window_older <= window_older_next;
      window_newer <= window_newer_next;
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      running_sum  <= running_sum_next;
      held_id      <= held_id_next;
      held_error   <= held_error_next;
    end
  end

  a_burst_end_hunts: assert property (@(posedge clk) disable iff (rst)
    step_en && item.burst_end |=> phase == PH_HUNT && window_older == 8'd0
      && window_newer == 8'd0)
    else $error("burst end did not return parser to hunting");

  a_nonlast_is_data: assert property (@(posedge clk) disable iff (rst)
    step_en && res_valid && !res.last |-> res.kind == KIND_DATA)
    else $error("non-final result is not a payload byte");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    step_en && phase == PH_DONE && !item.burst_end |-> !res_valid)
    else $error("result emitted after packet finished");

  a_hunt_no_data: assert property (@(posedge clk) disable iff (rst)
    step_en && (phase == PH_HUNT || phase == PH_LEN || phase == PH_ERR) && res_valid
      |-> res.kind == KIND_NO_PACKET)
    else $error("unexpected result before payload");

endmodule

// ----- design/sspp_out_stage.sv -----
module sspp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              load_valid,
  input  sspp_pkg::result_t load_res,
  output logic              slot_free,
  output logic              out_valid,
  input  logic              out_ready,
  output sspp_pkg::result_t out_res
);
  import sspp_pkg::*;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= load_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      out_res <= load_res;
    end
  end

endmodule

// ----- design/servo_status_packet_parser_core.sv -----
// Status packet parser for a serial-servo bus (protocol 1 framing).
// Slave stream: one received bus byte per transaction in s_tdata, with
// s_tlast marking the last byte of a receive burst.
// Master stream: zero or one result per input byte. m_tuser carries the
// kind (payload byte, packet good, checksum bad, no packet); m_tdata carries
// the payload byte, its index, the servo ID and the error byte; m_tlast is set
// on every end-of-packet or end-of-burst result.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 expected ID,
// 1 payload length, 2 any-ID enable); write only while the block is idle.
// Throughput: one byte per cycle while m_tready stays high; the parse step
// between the input register and the result register is combinational.
// m_tvalid rises once a byte's result is loaded into the result register.
// Reset (rst, synchronous) empties both registers, restores the register
// defaults and puts the parser back to hunting for a header.
// When m_tready is low with a result held, parsing stalls; the input register
// takes a byte only if empty, and s_tready is low until the result drains.
module servo_status_packet_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tlast,   // burst_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] data_byte, [15:8] data_index,
                                 // [23:16] servo_id, [31:24] status_error
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,   // last
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import sspp_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    slot_free;
  logic    advance;
  logic    res_valid;
  result_t res;
  result_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_id    <= 8'd1;
      cfg.payload_length <= 8'd2;
      cfg.match_any_id   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXPECTED_ID:    cfg.expected_id    <= cfg_data;
        REG_PAYLOAD_LENGTH: cfg.payload_length <= cfg_data;
        REG_MATCH_ANY_ID:   cfg.match_any_id   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_item.rx_byte   = s_tdata;
  assign in_item.burst_end = s_tlast;

  assign advance = held_valid && slot_free;

  sspp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  sspp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step_en   (advance),
    .item      (held_item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  sspp_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .load_valid (res_valid),
    .load_res   (res),
    .slot_free  (slot_free),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (out_res)
  );

  assign m_tdata = {out_res.status_error, out_res.servo_id,
                    out_res.data_index, out_res.data_byte};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

endmodule
